// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tilt angle block.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/taba_pkg.sv =====
// ------------------------------------------------------------------------
// taba_pkg
// Types, widths and constants shared by the tilt angle block modules.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package taba_pkg;

	// Default parameter values.
	localparam int WINDOW_DEF       = 8;
	localparam int CORDIC_STEPS_DEF = 16;

	// Field and state widths.
	localparam int SAMPLE_W   = 16;
	localparam int SCALE_W    = 15;
	localparam int CNT_W      = 4;
	localparam int SUM_W      = 20;
	localparam int AVG_W      = 25;
	localparam int ANG_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Averaging: the sum magnitude times a reciprocal of the window size
	// scaled by 2^RECIP_SHIFT. The rounding error of the reciprocal stays
	// below one quotient step for every sum a window of up to 15 can hold.
	localparam int FRAC_W      = 8;
	localparam int RECIP_SHIFT = 31;
	localparam int RECIP_W     = 32;
	localparam int QUOT_W      = 24;

	// CORDIC datapath.
	localparam int XY_W       = 28;
	localparam int ACC_W      = 26;
	localparam int DEG_W      = ACC_W - 16;
	localparam int ATAN_W     = 22;
	localparam int ATAN_IDX_W = 5;
	localparam int ANGLE_MAX  = 180;
	localparam logic signed [ACC_W-1:0] ACC_PLUS_90  = ACC_W'(90 * 65536);
	localparam logic signed [ACC_W-1:0] ACC_MINUS_90 = ACC_W'(-90 * 65536);

	// Rotation axis codes; the unused code behaves as the x axis.
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS     = 3'd0,
		REG_OFFSET_X = 3'd1,
		REG_OFFSET_Y = 3'd2,
		REG_OFFSET_Z = 3'd3,
		REG_SCALE_X  = 3'd4,
		REG_SCALE_Y  = 3'd5,
		REG_SCALE_Z  = 3'd6
	} cfg_reg_t;

	// Top-level sequencer.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_AVG,
		ST_CHECK,
		ST_CORD,
		ST_DONE
	} top_state_t;

	// CORDIC sequencer.
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ITER,
		CS_FIN
	} cordic_state_t;

	// Status returned by the CORDIC unit.
	typedef struct packed {
		logic                    done;
		logic signed [ANG_W-1:0] deg;
	} cordic_res_t;

	// atan(2^-i) in degrees with 16 fraction bits, rounded.
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] val;
		case (idx)
			5'd0:    val = 22'd2949120;
			5'd1:    val = 22'd1740967;
			5'd2:    val = 22'd919879;
			5'd3:    val = 22'd466945;
			5'd4:    val = 22'd234379;
			5'd5:    val = 22'd117304;
			5'd6:    val = 22'd58666;
			5'd7:    val = 22'd29335;
			5'd8:    val = 22'd14668;
			5'd9:    val = 22'd7334;
			5'd10:   val = 22'd3667;
			5'd11:   val = 22'd1833;
			5'd12:   val = 22'd917;
			5'd13:   val = 22'd458;
			5'd14:   val = 22'd229;
			5'd15:   val = 22'd115;
			5'd16:   val = 22'd57;
			5'd17:   val = 22'd29;
			5'd18:   val = 22'd14;
			5'd19:   val = 22'd7;
			5'd20:   val = 22'd4;
			5'd21:   val = 22'd2;
			5'd22:   val = 22'd1;
			default: val = 22'd0;
		endcase
		return val;
	endfunction

endpackage

// ===== rtl/taba_cordic.sv =====
// ------------------------------------------------------------------------
// taba_cordic
// Iterative vectoring CORDIC giving atan2(y, x) in whole degrees.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module taba_cordic
	import taba_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [AVG_W-1:0] x_in,
	input  logic signed [AVG_W-1:0] y_in,
	output cordic_res_t             res
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	cordic_state_t            state_q, state_d;
	logic [STEP_W-1:0]        step_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [XY_W-1:0]   xs, ys, dx, dy;
	logic signed [ACC_W-1:0]  atan_step, acc_neg;
	logic signed [DEG_W-1:0]  deg_full;

	// Inputs widened to the working width.
	assign xs = XY_W'(x_in);
	assign ys = XY_W'(y_in);

	// Shared shift and table lookup for the current step.
	assign dx        = y_q >>> step_q;
	assign dy        = x_q >>> step_q;
	assign atan_step = signed'({{(ACC_W-ATAN_W){1'b0}}, atan_q16(ATAN_IDX_W'(step_q))});

	// Truncate the angle toward zero to whole degrees, then clamp.
	assign acc_neg  = -acc_q;
	assign deg_full = acc_q[ACC_W-1] ? -signed'(acc_neg[ACC_W-1:16])
	                                 : signed'(acc_q[ACC_W-1:16]);

	always_comb begin
		res.done = (state_q == CS_FIN);
		if (deg_full > ANGLE_MAX) begin
			res.deg = ANG_W'(ANGLE_MAX);
		end else if (deg_full < -ANGLE_MAX) begin
			res.deg = ANG_W'(-ANGLE_MAX);
		end else begin
			res.deg = ANG_W'(deg_full);
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_d = (x_in == '0 && y_in == '0) ? CS_FIN : CS_ITER;
				end
			end
			CS_ITER: begin
				if (step_q == STEP_LAST) begin
					state_d = CS_FIN;
				end
			end
			CS_FIN:  state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_ITER) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Vector and angle registers: prerotation on start, one step per cycle.
	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && start) begin
			if (x_in == '0 && y_in == '0) begin
				x_q   <= '0;
				y_q   <= '0;
				acc_q <= '0;
			end else if (xs < 0 && ys >= 0) begin
				x_q   <= ys;
				y_q   <= -xs;
				acc_q <= ACC_PLUS_90;
			end else if (xs < 0) begin
				x_q   <= -ys;
				y_q   <= xs;
				acc_q <= ACC_MINUS_90;
			end else begin
				x_q   <= xs;
				y_q   <= ys;
				acc_q <= '0;
			end
		end else if (state_q == CS_ITER) begin
			if (y_q >= 0) begin
				x_q   <= x_q + dx;
				y_q   <= y_q - dy;
				acc_q <= acc_q + atan_step;
			end else begin
				x_q   <= x_q - dx;
				y_q   <= y_q + dy;
				acc_q <= acc_q - atan_step;
			end
		end
	end

	`ASSERT_NEVER(a_start_busy, clk, arst_n, start && state_q != CS_IDLE, "CORDIC started while busy")
	`ASSERT_CLK(a_fin_after_last, clk, arst_n, (state_q == CS_ITER && step_q == STEP_LAST) |=> (state_q == CS_FIN), "CORDIC did not finish after its last step")
	`ASSERT_CLK(a_deg_range, clk, arst_n, res.done |-> (res.deg <= ANGLE_MAX && res.deg >= -ANGLE_MAX), "CORDIC angle out of range")

endmodule

// ===== rtl/tilt_angle_block_average.sv =====
// Path: from input acceptance to tvalid a request passes the sequencer states CHECK, CORD
// and DONE; out-of-range averages skip CORD, a zero vector skips the CORDIC iterations,
// and a window-closing item adds DIV and AVG first. A new request is taken only in IDLE,
// once the last result is loaded; a result left waiting stalls the following request.
// Reset: arst_n clears the sequencer, window sums, averages, held angle and registers
// to their defaults (scales 16384, offsets and axis zero).
// ------------------------------------------------------------------------
// tilt_angle_block_average
// Block-averaged accelerometer tilt angle with an iterative CORDIC atan2.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tilt_angle_block_average
	import taba_pkg::*;
#(
	parameter int WINDOW       = WINDOW_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Sample input.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,   // accel_x, accel_y, accel_z
	// Result output.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata,   // angle_deg, average_first, average_second, zero fill
	output logic [1:0]            m_tuser    // angle_updated, averages_refreshed
);

	localparam logic [CNT_W-1:0]   WIN_CNT = CNT_W'(WINDOW);
	localparam longint             RECIP_L =
		((longint'(1) <<< RECIP_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_L);

	// Configuration registers.
	logic [1:0]                 axis_q;
	logic signed [SAMPLE_W-1:0] offset_x_q, offset_y_q, offset_z_q;
	logic [SCALE_W-1:0]         scale_x_q, scale_y_q, scale_z_q;

	// Block state.
	top_state_t                 state_q, state_d;
	logic [CNT_W-1:0]           window_count_q;
	logic signed [SUM_W-1:0]    sum_first_q, sum_second_q;
	logic signed [AVG_W-1:0]    avg_first_q, avg_second_q;
	logic signed [ANG_W-1:0]    held_angle_q;
	logic                       updated_q, refreshed_q;

	// Averaging datapath.
	logic [SUM_W-1:0]           mag_first_q, mag_second_q;
	logic [QUOT_W-1:0]          quot_first_q, quot_second_q;
	logic                       neg_first_q, neg_second_q;

	// Output register.
	logic                       m_tvalid_q;
	logic signed [ANG_W-1:0]    out_angle_q;
	logic signed [AVG_W-1:0]    out_avg_first_q, out_avg_second_q;
	logic                       out_updated_q, out_refreshed_q;

	logic signed [SAMPLE_W-1:0] accel_x, accel_y, accel_z;
	logic signed [SAMPLE_W-1:0] samp_first, samp_second, off_first, off_second;
	logic [SCALE_W-1:0]         sc_first, sc_second;
	logic signed [AVG_W-1:0]    lim_first, lim_second;
	logic [SUM_W-1:0]           mag_first, mag_second;
	logic [QUOT_W-1:0]          div_first, div_second;
	logic signed [AVG_W:0]      quot_first, quot_second, new_avg_first, new_avg_second;
	logic                       in_accept, window_full, in_range, cordic_start, out_load;
	cordic_res_t                cres;

	assign accel_x = s_tdata[15:0];
	assign accel_y = s_tdata[31:16];
	assign accel_z = s_tdata[47:32];

	// Axis selection: picks the sample pair, offsets and scales.
	always_comb begin
		case (axis_q)
			AXIS_Y: begin
				samp_first  = accel_x;    samp_second = accel_z;
				off_first   = offset_x_q; off_second  = offset_z_q;
				sc_first    = scale_x_q;  sc_second   = scale_z_q;
			end
			AXIS_Z: begin
				samp_first  = accel_x;    samp_second = accel_y;
				off_first   = offset_x_q; off_second  = offset_y_q;
				sc_first    = scale_x_q;  sc_second   = scale_y_q;
			end
			default: begin
				samp_first  = accel_y;    samp_second = accel_z;
				off_first   = offset_y_q; off_second  = offset_z_q;
				sc_first    = scale_y_q;  sc_second   = scale_z_q;
			end
		endcase
	end

	// Range test of the held averages against plus or minus scale.
	assign lim_first  = signed'({2'b00, sc_first, {FRAC_W{1'b0}}});
	assign lim_second = signed'({2'b00, sc_second, {FRAC_W{1'b0}}});
	assign in_range   = (avg_first_q <= lim_first) && (avg_first_q >= -lim_first) &&
	                    (avg_second_q <= lim_second) && (avg_second_q >= -lim_second);

	assign in_accept   = s_tvalid && s_tready;
	assign window_full = (window_count_q >= WIN_CNT);

	// Sum magnitudes; the quotient is formed unsigned and the sign put back.
	assign mag_first  = sum_first_q[SUM_W-1] ? SUM_W'(-sum_first_q) : SUM_W'(sum_first_q);
	assign mag_second = sum_second_q[SUM_W-1] ? SUM_W'(-sum_second_q) : SUM_W'(sum_second_q);

	// Magnitude times 256 over the window size, by reciprocal multiplication.
	assign div_first  = QUOT_W'(({{RECIP_W{1'b0}}, mag_first_q} * {{SUM_W{1'b0}}, RECIP_M})
	                    >> (RECIP_SHIFT - FRAC_W));
	assign div_second = QUOT_W'(({{RECIP_W{1'b0}}, mag_second_q} * {{SUM_W{1'b0}}, RECIP_M})
	                    >> (RECIP_SHIFT - FRAC_W));

	// Signed average minus offset, all in Q.8.
	assign quot_first     = signed'({2'b00, quot_first_q});
	assign quot_second    = signed'({2'b00, quot_second_q});
	assign new_avg_first  = (neg_first_q ? -quot_first : quot_first) -
	                        signed'({{2{off_first[SAMPLE_W-1]}}, off_first, {FRAC_W{1'b0}}});
	assign new_avg_second = (neg_second_q ? -quot_second : quot_second) -
	                        signed'({{2{off_second[SAMPLE_W-1]}}, off_second, {FRAC_W{1'b0}}});

	// Sequencer next state and handshake.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cordic_start = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = window_full ? ST_DIV : ST_CHECK;
				end
			end
			ST_DIV:  state_d = ST_AVG;
			ST_AVG:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (in_range) begin
					cordic_start = 1'b1;
					state_d      = ST_CORD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CORD: begin
				if (cres.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration writes; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q     <= AXIS_X;
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= '0;
			scale_x_q  <= 15'd16384;
			scale_y_q  <= 15'd16384;
			scale_z_q  <= 15'd16384;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AXIS:     axis_q     <= cfg_data[1:0];
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				REG_OFFSET_Z: offset_z_q <= cfg_data;
				REG_SCALE_X:  scale_x_q  <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y:  scale_y_q  <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Z:  scale_z_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Control and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_count_q <= '0;
			sum_first_q    <= '0;
			sum_second_q   <= '0;
			avg_first_q    <= '0;
			avg_second_q   <= '0;
			held_angle_q   <= '0;
			updated_q      <= 1'b0;
			refreshed_q    <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			// Window accumulation, or closing the window.
			if (in_accept) begin
				if (window_full) begin
					sum_first_q    <= '0;
					sum_second_q   <= '0;
					window_count_q <= '0;
					refreshed_q    <= 1'b1;
				end else begin
					sum_first_q    <= sum_first_q +
					                  {{(SUM_W-SAMPLE_W){samp_first[SAMPLE_W-1]}}, samp_first};
					sum_second_q   <= sum_second_q +
					                  {{(SUM_W-SAMPLE_W){samp_second[SAMPLE_W-1]}}, samp_second};
					window_count_q <= window_count_q + 1'b1;
					refreshed_q    <= 1'b0;
				end
			end

			if (state_q == ST_AVG) begin
				avg_first_q  <= AVG_W'(new_avg_first);
				avg_second_q <= AVG_W'(new_avg_second);
			end

			if (state_q == ST_CHECK) begin
				updated_q <= in_range;
			end

			if (state_q == ST_CORD && cres.done) begin
				held_angle_q <= cres.deg;
			end

			// Output valid: set on load, cleared once the request is taken.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Averaging datapath and output payload.
	always_ff @(posedge clk) begin
		if (in_accept && window_full) begin
			mag_first_q  <= mag_first;
			mag_second_q <= mag_second;
			neg_first_q  <= sum_first_q[SUM_W-1];
			neg_second_q <= sum_second_q[SUM_W-1];
		end

		if (state_q == ST_DIV) begin
			quot_first_q  <= div_first;
			quot_second_q <= div_second;
		end

		if (out_load) begin
			out_angle_q      <= held_angle_q;
			out_updated_q    <= updated_q;
			out_refreshed_q  <= refreshed_q;
			out_avg_first_q  <= avg_first_q;
			out_avg_second_q <= avg_second_q;
		end
	end

	taba_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x_in   (avg_second_q),
		.y_in   (avg_first_q),
		.res    (cres)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_avg_second_q, out_avg_first_q, out_angle_q};
	assign m_tuser  = {out_refreshed_q, out_updated_q};

	`ASSERT_CLK(a_count_bound, clk, arst_n, window_count_q <= WIN_CNT, "window count beyond window size")
	`ASSERT_CLK(a_full_divides, clk, arst_n, (in_accept && window_full) |=> (state_q == ST_DIV && window_count_q == '0), "closing item did not start the divider")
	`ASSERT_CLK(a_held_range, clk, arst_n, held_angle_q <= ANGLE_MAX && held_angle_q >= -ANGLE_MAX, "held angle out of range")

endmodule
